/* design/swrs_pkg.sv */
// ----------------------------------------------------------------------------
// swrs_pkg
// shared types and constants of the sliding window reorder sort block
// ----------------------------------------------------------------------------
package swrs_pkg;

	// configuration register
	localparam int unsigned CFG_W = 6;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd20;

	// input item kinds
	localparam int unsigned MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

	// control from the sequencer to the slot store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_valid;
		logic clear;
	} store_cmd_t;

endpackage

/* design/swrs_slots.sv */
// ----------------------------------------------------------------------------
// swrs_slots
// ring slot store: value and tag memory with registered read, valid flags
// ----------------------------------------------------------------------------
module swrs_slots
	import swrs_pkg::*;
#(
	parameter int unsigned MAX_SLOTS    = 32,
	parameter int unsigned VALUE_BITS   = 32,
	parameter int unsigned PAYLOAD_BITS = 32,
	localparam int unsigned IDX_W = $clog2(MAX_SLOTS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  store_cmd_t              cmd,
	input  logic [IDX_W-1:0]        rd_addr,
	input  logic [IDX_W-1:0]        wr_addr,
	input  logic [VALUE_BITS-1:0]   wr_value,
	input  logic [PAYLOAD_BITS-1:0] wr_payload,
	output logic                    rd_valid,
	output logic [VALUE_BITS-1:0]   rd_value,
	output logic [PAYLOAD_BITS-1:0] rd_payload
);

	logic [VALUE_BITS-1:0]   value_mem [MAX_SLOTS];
	logic [PAYLOAD_BITS-1:0] payload_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]    valid_q;
	logic [VALUE_BITS-1:0]   rd_value_q;
	logic [PAYLOAD_BITS-1:0] rd_payload_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			value_mem[wr_addr]   <= wr_value;
			payload_mem[wr_addr] <= wr_payload;
		end
		if (cmd.rd_en) begin
			rd_value_q   <= value_mem[rd_addr];
			rd_payload_q <= payload_mem[rd_addr];
			rd_valid_q   <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[wr_addr] <= cmd.wr_valid;
		end
	end

	// an empty slot reads as value zero, tag zero
	assign rd_valid   = rd_valid_q;
	assign rd_value   = rd_valid_q ? rd_value_q : '0;
	assign rd_payload = rd_valid_q ? rd_payload_q : '0;

endmodule

/* design/sliding_window_reorder_sort_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_reorder_sort_top
// streaming window sort over one signed key with a ring of up to MAX_SLOTS
// ----------------------------------------------------------------------------
// Events come in on the s_ side (tuser = mode, tdata = sort value then tag)
// and leave on the m_ side in sort order once they fall out of the window;
// tlast marks the final result caused by one input transfer. The slots sit in
// a single-port-read memory and every step goes through one shared signed
// comparator, so the block takes one input transfer at a time and drops
// s_tready until its work is done. An insert reads the newest slot, then the
// head slot, and then either writes at the head or passes straight through;
// one that has to slot in between also walks from the head toward the newest
// slot, shifting each slot at or below the item one place toward the oldest
// end. An expire that fires or a flush visits every slot in use (window_size,
// zero counted as one, clamped at MAX_SLOTS), reading each through the one
// memory read port before handing it over. A stalled m_tready holds the
// sequencer only at a cycle where a result has to be handed over. Writing the
// window size (cfg_data) empties the ring without results; it is taken only
// while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_reorder_sort_top
	import swrs_pkg::*;
#(
	parameter int unsigned MAX_SLOTS    = 32,
	parameter int unsigned VALUE_BITS   = 32,
	parameter int unsigned PAYLOAD_BITS = 32,
	localparam int unsigned DATA_W = ((VALUE_BITS + PAYLOAD_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,   // window_size
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,    // sort_value, payload, zero fill
	input  logic [MODE_W-1:0] s_tuser,    // mode
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,    // payload_res, sort_value_res, zero fill
	output logic              m_tlast
);

	localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
	localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,  // waiting for a transfer or a config write
		S_CMP_P  = 7'b0000010,  // newest slot data back, read the head slot
		S_HEAD   = 7'b0000100,  // head slot data back, pick the insert case
		S_SHIFT  = 7'b0001000,  // move slots toward the oldest until the gap
		S_DR_RD  = 7'b0010000,  // drain: read next slot
		S_DR_CHK = 7'b0100000,  // drain: hand over the held entry
		S_DR_END = 7'b1000000   // drain: last result, empty the ring
	} state_t;

	state_t state_q, state_d;

	// configuration and ring bookkeeping
	logic [CFG_W-1:0] window_q, window_d;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] head_q, head_d;
	logic             ever_q, ever_d;
	logic             period_q, period_d;

	// current item
	logic [VALUE_BITS-1:0]   v_q, v_d;
	logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
	logic                    hit_q, hit_d;   // item goes in at the head

	// walk over the slots
	logic [IDX_W-1:0] prev_q, prev_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// drain keeps one entry back so the final one can carry tlast
	logic                    pend_q, pend_d;
	logic [VALUE_BITS-1:0]   pend_val_q, pend_val_d;
	logic [PAYLOAD_BITS-1:0] pend_pay_q, pend_pay_d;

	// output register
	logic                    out_valid_q;
	logic [VALUE_BITS-1:0]   out_val_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic                    out_last_q;
	logic                    out_free;
	logic                    emit;
	logic [VALUE_BITS-1:0]   emit_val;
	logic [PAYLOAD_BITS-1:0] emit_pay;
	logic                    emit_last;

	// slot store interface
	store_cmd_t              cmd;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        wr_addr;
	logic [VALUE_BITS-1:0]   wr_value;
	logic [PAYLOAD_BITS-1:0] wr_payload;
	logic                    rd_valid;
	logic [VALUE_BITS-1:0]   rd_value;
	logic [PAYLOAD_BITS-1:0] rd_payload;

	// the shared compare unit: stored value at or below the item value
	logic le;

	logic             s_xfer;
	logic             cfg_xfer;
	logic [IDX_W-1:0] p_idx;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
		input logic [CNT_W-1:0] n);
		logic [IDX_W-1:0] r;
		r = x + 1'b1;
		if (CNT_W'(x) + 1'b1 == n) begin
			r = '0;
		end
		return r;
	endfunction

	// slots in use: zero counts as one, clamp at the ring size
	always_comb begin
		if (window_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (CNT_W'(window_q) > CNT_W'(MAX_SLOTS) || window_q > MAX_SLOTS) begin
			n_eff = CNT_W'(MAX_SLOTS);
		end else begin
			n_eff = CNT_W'(window_q);
		end
	end

	// newest slot sits just behind the head
	assign p_idx = (head_q == '0) ? IDX_W'(n_eff - 1'b1) : head_q - 1'b1;

	assign le       = $signed(rd_value) <= $signed(v_q);
	assign out_free = !out_valid_q || m_tready;

	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign s_xfer    = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		window_d   = window_q;
		head_d     = head_q;
		ever_d     = ever_q;
		period_d   = period_q;
		v_d        = v_q;
		pay_d      = pay_q;
		hit_d      = hit_q;
		prev_d     = prev_q;
		cur_d      = cur_q;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		pend_val_d = pend_val_q;
		pend_pay_d = pend_pay_q;

		cmd        = '0;
		rd_addr    = head_q;
		wr_addr    = head_q;
		wr_value   = v_q;
		wr_payload = pay_q;

		emit      = 1'b0;
		emit_val  = rd_value;
		emit_pay  = rd_payload;
		emit_last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (cfg_xfer) begin
					window_d  = cfg_data;
					cmd.clear = 1'b1;
					head_d    = '0;
					ever_d    = 1'b0;
					period_d  = 1'b0;
				end else if (s_xfer) begin
					v_d   = s_tdata[VALUE_BITS-1:0];
					pay_d = s_tdata[VALUE_BITS+PAYLOAD_BITS-1:VALUE_BITS];
					cur_d = head_q;
					cnt_d = '0;
					priority if (s_tuser == MODE_INSERT) begin
						ever_d     = 1'b1;
						period_d   = 1'b1;
						cmd.rd_en  = 1'b1;
						rd_addr    = p_idx;
						state_d    = S_CMP_P;
					end else if (s_tuser == MODE_EXPIRE) begin
						period_d = 1'b0;
						if (ever_q && !period_q) begin
							state_d = S_DR_RD;
						end
					end else if (s_tuser == MODE_FLUSH) begin
						state_d = S_DR_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end

			S_CMP_P: begin
				hit_d     = !rd_valid || le;
				cmd.rd_en = 1'b1;
				rd_addr   = head_q;
				state_d   = S_HEAD;
			end

			S_HEAD: begin
				// waits only when a result leaves: a held head or a pass-through
				if (out_free || !(rd_valid || (!hit_q && !le))) begin
					emit = rd_valid;
					if (hit_q) begin
						// occupant leaves, new item takes the head
						cmd.wr_en    = 1'b1;
						cmd.wr_valid = 1'b1;
						wr_addr      = head_q;
						head_d       = wrap_inc(head_q, n_eff);
						state_d      = S_IDLE;
					end else if (!le) begin
						// below the oldest: passes straight through
						emit     = 1'b1;
						emit_val = v_q;
						emit_pay = pay_q;
						state_d  = S_IDLE;
					end else begin
						// oldest leaves, walk toward the newest for the gap
						prev_d    = head_q;
						cur_d     = wrap_inc(head_q, n_eff);
						cnt_d     = CNT_W'(1);
						cmd.rd_en = 1'b1;
						rd_addr   = wrap_inc(head_q, n_eff);
						state_d   = S_SHIFT;
					end
				end
			end

			S_SHIFT: begin
				cmd.wr_en = 1'b1;
				wr_addr   = prev_q;
				if (cnt_q < n_eff && le) begin
					cmd.wr_valid = rd_valid;
					wr_value     = rd_value;
					wr_payload   = rd_payload;
					prev_d       = cur_q;
					cur_d        = wrap_inc(cur_q, n_eff);
					cnt_d        = cnt_q + 1'b1;
					// no read once the walk has reached the newest slot
					cmd.rd_en    = (cnt_q + 1'b1 < n_eff);
					rd_addr      = wrap_inc(cur_q, n_eff);
				end else begin
					cmd.wr_valid = 1'b1;
					state_d      = S_IDLE;
				end
			end

			S_DR_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = cur_q;
				state_d   = S_DR_CHK;
			end

			S_DR_CHK: begin
				if (!(rd_valid && pend_q && !out_free)) begin
					if (rd_valid) begin
						emit       = pend_q;
						emit_val   = pend_val_q;
						emit_pay   = pend_pay_q;
						emit_last  = 1'b0;
						pend_d     = 1'b1;
						pend_val_d = rd_value;
						pend_pay_d = rd_payload;
					end
					cur_d = wrap_inc(cur_q, n_eff);
					cnt_d = cnt_q + 1'b1;
					if (cnt_q + 1'b1 == n_eff) begin
						state_d = S_DR_END;
					end else begin
						state_d = S_DR_RD;
					end
				end
			end

			S_DR_END: begin
				if (!pend_q || out_free) begin
					emit      = pend_q;
					emit_val  = pend_val_q;
					emit_pay  = pend_pay_q;
					emit_last = 1'b1;
					pend_d    = 1'b0;
					cmd.clear = 1'b1;
					head_d    = '0;
					ever_d    = 1'b0;
					period_d  = 1'b0;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	swrs_slots #(
		.MAX_SLOTS   (MAX_SLOTS),
		.VALUE_BITS  (VALUE_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_value  (wr_value),
		.wr_payload(wr_payload),
		.rd_valid  (rd_valid),
		.rd_value  (rd_value),
		.rd_payload(rd_payload)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= WINDOW_RESET;
			head_q      <= '0;
			ever_q      <= 1'b0;
			period_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			window_q <= window_d;
			head_q   <= head_d;
			ever_q   <= ever_d;
			period_q <= period_d;
			pend_q   <= pend_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		v_q        <= v_d;
		pay_q      <= pay_d;
		hit_q      <= hit_d;
		prev_q     <= prev_d;
		cur_q      <= cur_d;
		cnt_q      <= cnt_d;
		pend_val_q <= pend_val_d;
		pend_pay_q <= pend_pay_d;
		if (emit) begin
			out_val_q  <= emit_val;
			out_pay_q  <= emit_pay;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = DATA_W'({out_val_q, out_pay_q});

	// head always points inside the ring in use
	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(head_q) < n_eff)
		else $error("head index outside the ring");

	// the walk never reads the slot it writes in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
		else $error("slot read and write collide");

	// a drain always hands over its held entry before taking new work
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_q)
		else $error("drain entry left behind");

	// a result is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwritten in output register");

endmodule

/* dv/swrs_sort_checker.sv */
// ----------------------------------------------------------------------------
// swrs_sort_checker
// watches the config, input and result channels of the window sort block,
// predicts the emitted events and compares every result transfer
// ----------------------------------------------------------------------------
module swrs_sort_checker
	import swrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [63:0]       s_tdata,    // sort_value, payload
	input  logic [MODE_W-1:0] s_tuser,    // mode
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [63:0]       m_tdata,    // payload_res, sort_value_res
	input  logic              m_tlast,
	output int                errors,
	output int                pending
);

	localparam int unsigned SLOTS = 32;

	typedef struct {
		logic [31:0]        tag;
		logic signed [31:0] key;
		logic               last;
	} sorted_item_t;

	logic signed [31:0] key_mem [SLOTS];
	logic [31:0]        tag_mem [SLOTS];
	logic               held [SLOTS];
	int unsigned        head;
	logic               seen_insert;
	logic               insert_since_tick;
	logic [CFG_W-1:0]   window;
	sorted_item_t       outgoing [$];

	// zero and oversize window settings fold into the legal range
	function automatic int unsigned ring_len();
		if (window == 0) return 1;
		if (window > SLOTS) return SLOTS;
		return window;
	endfunction

	task automatic push_out(logic signed [31:0] k, logic [31:0] t);
		sorted_item_t e;
		e.tag = t;
		e.key = k;
		e.last = 1'b0;
		outgoing.push_back(e);
	endtask

	task automatic empty_ring();
		for (int i = 0; i < SLOTS; i++) begin
			key_mem[i] = '0;
			tag_mem[i] = '0;
			held[i] = 1'b0;
		end
		head = 0;
		seen_insert = 1'b0;
		insert_since_tick = 1'b0;
	endtask

	// oldest to newest, then everything cleared
	task automatic drain_ring();
		int unsigned n;
		int unsigned k;
		n = ring_len();
		for (int i = 0; i < n; i++) begin
			k = (head + i) % n;
			if (held[k]) push_out(key_mem[k], tag_mem[k]);
		end
		empty_ring();
	endtask

	task automatic sort_insert(logic signed [31:0] k, logic [31:0] t);
		int unsigned n, h, p, prev, cur;
		bit stop;
		n = ring_len();
		h = head % n;
		p = (h + n - 1) % n;
		if (!held[p] || key_mem[p] <= k) begin
			// in order: goes in at the head, occupant leaves first
			if (held[h]) push_out(key_mem[h], tag_mem[h]);
			key_mem[h] = k;
			tag_mem[h] = t;
			held[h] = 1'b1;
			head = (h + 1) % n;
		end else if (key_mem[h] > k) begin
			// older than everything held: straight out
			push_out(k, t);
		end else begin
			// oldest leaves, entries at or below the key slide toward the oldest end
			if (held[h]) push_out(key_mem[h], tag_mem[h]);
			prev = h;
			stop = 1'b0;
			for (int i = 1; i < n && !stop; i++) begin
				cur = (h + i) % n;
				if (key_mem[cur] <= k) begin
					key_mem[prev] = key_mem[cur];
					tag_mem[prev] = tag_mem[cur];
					held[prev] = held[cur];
					prev = cur;
				end else begin
					stop = 1'b1;
				end
			end
			key_mem[prev] = k;
			tag_mem[prev] = t;
			held[prev] = 1'b1;
		end
	endtask

	task automatic predict(logic [MODE_W-1:0] mode, logic signed [31:0] k, logic [31:0] t);
		int unsigned first;
		first = outgoing.size();
		case (mode)
			MODE_INSERT: begin
				seen_insert = 1'b1;
				insert_since_tick = 1'b1;
				sort_insert(k, t);
			end
			MODE_EXPIRE: begin
				// fires only on a quiet period after some activity
				if (seen_insert && !insert_since_tick) drain_ring();
				insert_since_tick = 1'b0;
			end
			MODE_FLUSH: begin
				drain_ring();
			end
			default: ;
		endcase
		if (outgoing.size() > first) outgoing[outgoing.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_item_t got;
		sorted_item_t want;
		if (!arst_n) begin
			empty_ring();
			window = WINDOW_RESET;
			outgoing.delete();
			errors = 0;
		end else begin
			// results leave registered, so compare before taking new input
			if (m_tvalid && m_tready) begin
				got.tag = m_tdata[31:0];
				got.key = m_tdata[63:32];
				got.last = m_tlast;
				if (outgoing.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, actual tag %h key %0d last %b",
						$time, got.tag, got.key, got.last);
				end else begin
					want = outgoing.pop_front();
					if (got.tag !== want.tag) begin
						errors++;
						$display("%0t payload mismatch: expected %h, actual %h",
							$time, want.tag, got.tag);
					end
					if (got.key !== want.key) begin
						errors++;
						$display("%0t sort value mismatch: expected %0d, actual %0d",
							$time, want.key, got.key);
					end
					if (got.last !== want.last) begin
						errors++;
						$display("%0t last mismatch: expected %b, actual %b",
							$time, want.last, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				window = cfg_data;
				empty_ring();
			end
			if (s_tvalid && s_tready) predict(s_tuser, s_tdata[31:0], s_tdata[63:32]);
		end
		pending = outgoing.size();
	end

endmodule

/* dv/sliding_window_reorder_sort_top_tb.sv */
// ----------------------------------------------------------------------------
// sliding_window_reorder_sort_top_tb
// stimulus and verdict for the sliding window reorder sort block
// ----------------------------------------------------------------------------
// A directed run through empty ticks, extreme keys, ties, late events and
// flushes is followed by random phases at several window sizes, including the
// out-of-range settings. Both stream sides idle in random bursts, the result
// side holds off once long enough for the block to stall its input. The
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module sliding_window_reorder_sort_top_tb
	import swrs_pkg::*;
();

	localparam int unsigned DATA_W = 64;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// window sizes for the random phases, the last one runs without idling
	localparam int unsigned PHASES = 9;
	localparam logic [CFG_W-1:0] WINDOW_PLAN [PHASES] = '{
		6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd5, 6'd20, 6'd17, 6'd9
	};
	localparam int unsigned PHASE_ITEMS = 30;
	// longest item: expire or flush over a full ring, plus margin
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;    // sort_value, payload
	logic [MODE_W-1:0] s_tuser = '0;    // mode
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [DATA_W-1:0] m_tdata;         // payload_res, sort_value_res
	logic              m_tlast;

	int          errors;
	int          pending;
	int unsigned items_sent = 0;
	bit          calm = 1'b0;      // no idling on either side
	int          ramp = 0;         // slowly rising key for near-ordered streams

	sliding_window_reorder_sort_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	swrs_sort_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// one input transfer, optionally after a random gap
	task automatic send(logic [MODE_W-1:0] mode, logic [31:0] key, logic [31:0] tag);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {tag, key};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// only while idle: every result out, then time for silent work to finish
	task automatic set_window(logic [CFG_W-1:0] size);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly near-ordered keys so the reorder path gets work, some wide spread
	function automatic logic [31:0] pick_key();
		int unsigned r;
		int j;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			j = $urandom_range(0, 3);
			ramp = ramp + j;
			j = $urandom_range(0, 8);
			return ramp + j - 4;
		end
		if (r < 7) begin
			j = $urandom_range(0, 40);
			return j - 20;
		end
		if (r < 9) return $urandom();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	task automatic random_item();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 82) begin
			send(MODE_INSERT, pick_key(), $urandom());
		end else if (r < 91) begin
			// back-to-back ticks make an expire actually fire
			send(MODE_EXPIRE, $urandom(), $urandom());
			if ($urandom_range(0, 1)) send(MODE_EXPIRE, $urandom(), $urandom());
		end else if (r < 97) begin
			send(MODE_FLUSH, $urandom(), $urandom());
		end else begin
			// unused mode is ignored, follow it with real work
			send(MODE_UNUSED, $urandom(), $urandom());
			send(MODE_INSERT, pick_key(), $urandom());
		end
	endtask

	// result side: random stalls, free stretches, one long hold-off
	initial begin
		bit held_off;
		int unsigned r;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 9);
			if (!held_off && items_sent >= 40) begin
				// block fills up and must drop s_tready meanwhile
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && r < 2) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end else if (r == 2) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset window: empty ticks, unused mode, extreme keys
		send(MODE_EXPIRE, 32'h0, 32'h0);
		send(MODE_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
		send(MODE_UNUSED, $urandom(), $urandom());
		send(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
		send(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		send(MODE_INSERT, 32'h7fff_ffff, 32'h0000_0001);   // tie goes in at head
		send(MODE_INSERT, 32'h8000_0000, 32'h8000_0000);   // below oldest, out at once
		send(MODE_INSERT, 32'hffff_ffff, 32'h0000_0002);
		send(MODE_INSERT, 32'h0000_0005, 32'h0000_0003);   // slides into an empty slot
		send(MODE_EXPIRE, 32'h0, 32'h0);                   // period had inserts, no fire
		send(MODE_EXPIRE, 32'h0, 32'h0);                   // quiet period, drains
		send(MODE_EXPIRE, 32'h0, 32'h0);                   // ring empty again
		send(MODE_INSERT, 32'h0000_0007, 32'h0000_0004);
		send(MODE_INSERT, 32'h0000_0007, 32'h0000_0005);
		send(MODE_FLUSH, 32'h0, 32'h0);

		// directed, three slots: full ring, reorder with eviction, late event
		set_window(6'd3);
		send(MODE_INSERT, 32'd10, 32'h0000_0010);
		send(MODE_INSERT, 32'd20, 32'h0000_0020);
		send(MODE_INSERT, 32'd30, 32'h0000_0030);
		send(MODE_INSERT, 32'd25, 32'h0000_0025);
		send(MODE_INSERT, 32'd5, 32'h0000_0005);
		send(MODE_INSERT, 32'd40, 32'h0000_0040);
		send(MODE_INSERT, 32'd40, 32'h0000_0041);
		send(MODE_FLUSH, 32'h0, 32'h0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) calm = 1'b1;
			set_window(WINDOW_PLAN[ph]);
			repeat (PHASE_ITEMS) random_item();
		end

		// drain and let any stray result show up
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/swrs_pkg.sv
design/swrs_slots.sv
design/sliding_window_reorder_sort_top.sv
dv/swrs_sort_checker.sv
dv/sliding_window_reorder_sort_top_tb.sv
